/* rtl/bfks_pkg.sv */
`default_nettype none
package bfks_pkg;

	localparam int ACTION_W = 2;
	localparam int KEY_W = 32;
	localparam int CFG_W = 12;
	localparam int OUT_CNT_W = 12;

	localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ADD = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

	localparam logic [CFG_W-1:0] MAX_KEYS_RESET = 12'd2000;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DISPATCH,
		ST_UL_RD,
		ST_UL_WR,
		ST_APPEND,
		ST_TRIM,
		ST_FINISH
	} state_t;

endpackage
`default_nettype wire

/* rtl/bounded_fifo_key_store.sv */
// channel   | handshake                       | payload
// cfg       | cfg_valid / cfg_ready           | cfg_data (max_keys)
// in        | in_valid / in_stall             | action, iteration, seed_word
// out       | out_valid / out_stall           | found, seed_out, entry_count, evicted_count
//
// one request at a time; a linear scan of the key memory, one slot a cycle, sets the pace:
// a query or a remove miss runs the scan, dispatch and finish; an unlink reads and then
// writes the links; an append is followed by a trim check, each trimmed entry unlinked
// after reset a clearing pass zeroes the valid memory, in_stall high
// a finished result sits in the output register while the next request is taken
// out_stall holds the result; cfg writes are taken every cycle
`default_nettype none
module bounded_fifo_key_store #(
	parameter int CAPACITY = 2048,
	parameter int DATA_BITS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bfks_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [bfks_pkg::ACTION_W-1:0]        action,
	input  logic [bfks_pkg::KEY_W-1:0]           iteration,
	input  logic [DATA_BITS-1:0]                 seed_word,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 found,
	output logic [DATA_BITS-1:0]                 seed_out,
	output logic [bfks_pkg::OUT_CNT_W-1:0]       entry_count,
	output logic [bfks_pkg::OUT_CNT_W-1:0]       evicted_count
);
	import bfks_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > CFG_W) ? CW : CFG_W;

	logic [KEY_W-1:0]     key_mem  [CAPACITY];
	logic [DATA_BITS-1:0] data_mem [CAPACITY];
	logic                 valid_mem[CAPACITY];
	logic [AW-1:0]        next_mem [CAPACITY];
	logic [AW-1:0]        prev_mem [CAPACITY];

	state_t state_q, state_d, ret_q, ret_d;
	logic [AW-1:0] clr_q;
	logic [AW:0] scan_q;
	logic chk_vld_s1;
	logic [AW-1:0] chk_idx_s1;
	logic [KEY_W-1:0] key_rd_s1;
	logic valid_rd_s1;
	logic [AW-1:0] next_rd_s1, prev_rd_s1;
	logic [DATA_BITS-1:0] data_rd_s1;

	logic [ACTION_W-1:0] act_q;
	logic [KEY_W-1:0] key_q;
	logic [DATA_BITS-1:0] seed_q;
	logic hit_q, free_found_q;
	logic [AW-1:0] hit_idx_q, free_idx_q, tgt_q, oldest_q, newest_q;
	logic [CW-1:0] count_q, evict_q;
	logic [DATA_BITS-1:0] rm_seed_q;
	logic [CFG_W-1:0] max_keys_q;

	logic out_valid_q, found_q;
	logic [DATA_BITS-1:0] seed_out_q;
	logic [OUT_CNT_W-1:0] entry_count_q, evicted_count_q;

	logic tgt_load, free_load, evict_inc;
	logic [AW-1:0] tgt_d, free_d;
	logic key_we, data_we, vld_we, vld_wd, next_we, prev_we;
	logic [AW-1:0] vld_wa, next_wa, next_wd, prev_wa, prev_wd;
	logic scan_done, full, over_limit, accept, finish_go;
	logic [LW-1:0] mk_ext, lim_ext;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && (state_q == ST_IDLE);
	assign scan_done = (scan_q == (AW+1)'(CAPACITY));
	assign full = (count_q >= CW'(CAPACITY));
	assign mk_ext = (max_keys_q == '0) ? LW'(1) : LW'(max_keys_q);
	assign lim_ext = (mk_ext > LW'(CAPACITY)) ? LW'(CAPACITY) : mk_ext;
	assign over_limit = (LW'(count_q) > lim_ext);
	assign finish_go = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign seed_out = seed_out_q;
	assign entry_count = entry_count_q;
	assign evicted_count = evicted_count_q;

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		tgt_load = 1'b0;
		tgt_d = tgt_q;
		free_load = 1'b0;
		free_d = free_idx_q;
		evict_inc = 1'b0;
		key_we = 1'b0;
		data_we = 1'b0;
		vld_we = 1'b0;
		vld_wa = tgt_q;
		vld_wd = 1'b0;
		next_we = 1'b0;
		next_wa = prev_rd_s1;
		next_wd = next_rd_s1;
		prev_we = 1'b0;
		prev_wa = next_rd_s1;
		prev_wd = prev_rd_s1;
		unique case (state_q)
			ST_CLEAR: begin
				vld_we = 1'b1;
				vld_wa = clr_q;
				if (clr_q == AW'(CAPACITY - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (act_q == ACT_REMOVE && hit_q) begin
					tgt_load = 1'b1;
					tgt_d = hit_idx_q;
					ret_d = ST_FINISH;
					state_d = ST_UL_RD;
				end else if (act_q == ACT_ADD) begin
					if (hit_q) begin
						tgt_load = 1'b1;
						tgt_d = hit_idx_q;
						ret_d = ST_APPEND;
						free_load = 1'b1;
						free_d = (free_found_q && free_idx_q < hit_idx_q) ? free_idx_q
							: hit_idx_q;
						state_d = ST_UL_RD;
					end else if (full) begin
						tgt_load = 1'b1;
						tgt_d = oldest_q;
						ret_d = ST_APPEND;
						free_load = 1'b1;
						free_d = oldest_q;
						evict_inc = 1'b1;
						state_d = ST_UL_RD;
					end else begin
						state_d = ST_APPEND;
					end
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_UL_RD: begin
				state_d = ST_UL_WR;
			end
			ST_UL_WR: begin
				vld_we = 1'b1;
				next_we = (tgt_q != oldest_q);
				prev_we = (tgt_q != newest_q);
				state_d = ret_q;
			end
			ST_APPEND: begin
				key_we = 1'b1;
				data_we = 1'b1;
				vld_we = 1'b1;
				vld_wa = free_idx_q;
				vld_wd = 1'b1;
				next_we = (count_q != '0);
				next_wa = newest_q;
				next_wd = free_idx_q;
				prev_we = (count_q != '0);
				prev_wa = free_idx_q;
				prev_wd = newest_q;
				state_d = ST_TRIM;
			end
			ST_TRIM: begin
				if (over_limit) begin
					tgt_load = 1'b1;
					tgt_d = oldest_q;
					ret_d = ST_TRIM;
					evict_inc = 1'b1;
					state_d = ST_UL_RD;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (finish_go) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[free_idx_q] <= key_q;
		end
		key_rd_s1 <= key_mem[scan_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (vld_we) begin
			valid_mem[vld_wa] <= vld_wd;
		end
		valid_rd_s1 <= valid_mem[scan_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[free_idx_q] <= seed_q;
		end
		data_rd_s1 <= data_mem[tgt_q];
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		next_rd_s1 <= next_mem[tgt_q];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		prev_rd_s1 <= prev_mem[tgt_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q <= ST_FINISH;
			clr_q <= '0;
			scan_q <= '0;
			chk_vld_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
			oldest_q <= '0;
			newest_q <= '0;
			count_q <= '0;
			evict_q <= '0;
			max_keys_q <= MAX_KEYS_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_keys_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept) begin
				scan_q <= '0;
				hit_q <= 1'b0;
				free_found_q <= 1'b0;
				evict_q <= '0;
			end
			chk_vld_s1 <= (state_q == ST_SCAN) && !scan_done;
			if (state_q == ST_SCAN && !scan_done) begin
				scan_q <= scan_q + (AW+1)'(1);
			end
			if (chk_vld_s1) begin
				if (valid_rd_s1 && key_rd_s1 == key_q && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!valid_rd_s1 && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (tgt_load) begin
				ret_q <= ret_d;
			end
			if (evict_inc) begin
				evict_q <= evict_q + CW'(1);
			end
			if (state_q == ST_UL_WR) begin
				if (count_q == CW'(1)) begin
					oldest_q <= '0;
					newest_q <= '0;
				end else begin
					if (tgt_q == oldest_q) begin
						oldest_q <= next_rd_s1;
					end
					if (tgt_q == newest_q) begin
						newest_q <= prev_rd_s1;
					end
				end
				count_q <= count_q - CW'(1);
			end
			if (state_q == ST_APPEND) begin
				if (count_q == '0) begin
					oldest_q <= free_idx_q;
				end
				newest_q <= free_idx_q;
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_FINISH && finish_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			key_q <= iteration;
			seed_q <= seed_word;
			rm_seed_q <= '0;
		end
		if (chk_vld_s1) begin
			if (valid_rd_s1 && key_rd_s1 == key_q && !hit_q) begin
				hit_idx_q <= chk_idx_s1;
			end
			if (!valid_rd_s1 && !free_found_q) begin
				free_idx_q <= chk_idx_s1;
			end
		end
		chk_idx_s1 <= scan_q[AW-1:0];
		if (tgt_load) begin
			tgt_q <= tgt_d;
		end
		if (free_load) begin
			free_idx_q <= free_d;
		end
		if (state_q == ST_UL_WR && act_q == ACT_REMOVE) begin
			rm_seed_q <= data_rd_s1;
		end
		if (state_q == ST_FINISH && finish_go) begin
			found_q <= hit_q;
			seed_out_q <= rm_seed_q;
			entry_count_q <= OUT_CNT_W'(count_q);
			evicted_count_q <= OUT_CNT_W'(evict_q);
		end
	end

endmodule
`default_nettype wire

/* rtl/bfks_checker.sv */
`default_nettype none
module bfks_checker #(
	parameter int DATA_BITS = 64
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 found,
	input logic [DATA_BITS-1:0] seed_out
);

	// one request in flight: the input stalls right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while another is in flight");

	// clearing pass keeps the input stalled after reset
	a_clear_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> in_stall)
		else $error("input open during clearing pass");

	// only a remove hit returns data
	a_miss_no_seed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> seed_out == '0)
		else $error("data returned on a miss");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(seed_out) && $stable(found))
		else $error("stalled result changed");

endmodule

bind bounded_fifo_key_store bfks_checker #(.DATA_BITS(DATA_BITS)) u_bfks_checker (.*);
`default_nettype wire

/* sim/bounded_fifo_key_store_checker.sv */
`default_nettype none
module bounded_fifo_key_store_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	input  wire logic                                cfg_ready,
	input  wire logic [bfks_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                in_valid,
	input  wire logic                                in_stall,
	input  wire logic [bfks_pkg::ACTION_W-1:0]       action,
	input  wire logic [bfks_pkg::KEY_W-1:0]          iteration,
	input  wire logic [63:0]                         seed_word,
	input  wire logic                                out_valid,
	input  wire logic                                out_stall,
	input  wire logic                                found,
	input  wire logic [63:0]                         seed_out,
	input  wire logic [bfks_pkg::OUT_CNT_W-1:0]      entry_count,
	input  wire logic [bfks_pkg::OUT_CNT_W-1:0]      evicted_count,
	output int                                       fail_count,
	output int                                       awaiting,
	output int                                       checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_SLOTS = 2048;

	typedef struct packed {
		logic                               hit;
		logic [63:0]                        seed;
		logic [bfks_pkg::OUT_CNT_W-1:0]     count;
		logic [bfks_pkg::OUT_CNT_W-1:0]     dropped;
	} key_result_t;

	// insertion order: index 0 is the oldest entry
	logic [bfks_pkg::KEY_W-1:0] store_keys[$];
	logic [63:0]                store_seeds[$];
	logic [bfks_pkg::CFG_W-1:0] limit_reg;
	key_result_t                pending_results[$];

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	function automatic key_result_t predict_key_store(input logic [1:0] act,
		input logic [31:0] key, input logic [63:0] seed);
		key_result_t r;
		int pos;
		int lim;
		pos = -1;
		r = '0;
		foreach (store_keys[i])
			if (store_keys[i] == key)
				pos = i;
		r.hit = (pos >= 0);
		if (act == bfks_pkg::ACT_ADD) begin
			lim = (limit_reg == 0) ? 1 : int'(limit_reg);
			if (lim > STORE_SLOTS)
				lim = STORE_SLOTS;
			if (pos >= 0) begin
				store_keys.delete(pos);
				store_seeds.delete(pos);
			end
			if (store_keys.size() >= STORE_SLOTS) begin
				store_keys.delete(0);
				store_seeds.delete(0);
				r.dropped++;
			end
			store_keys.insert(store_keys.size(), key);
			store_seeds.insert(store_seeds.size(), seed);
			while (store_keys.size() > lim) begin
				store_keys.delete(0);
				store_seeds.delete(0);
				r.dropped++;
			end
		end else if (act == bfks_pkg::ACT_REMOVE && pos >= 0) begin
			r.seed = store_seeds[pos];
			store_keys.delete(pos);
			store_seeds.delete(pos);
		end
		r.count = 12'(store_keys.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		key_result_t w;
		if (!arst_n) begin
			store_keys.delete();
			store_seeds.delete();
			pending_results.delete();
			limit_reg = bfks_pkg::MAX_KEYS_RESET;
			fail_count = 0;
			awaiting = 0;
			checked = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report("unexpected result", 64'(entry_count), 64'd0);
				end else begin
					w = pending_results[0];
					pending_results.delete(0);
					if (found !== w.hit)
						report("found", 64'(found), 64'(w.hit));
					if (seed_out !== w.seed)
						report("seed_out", seed_out, w.seed);
					if (entry_count !== w.count)
						report("entry_count", 64'(entry_count), 64'(w.count));
					if (evicted_count !== w.dropped)
						report("evicted_count", 64'(evicted_count), 64'(w.dropped));
				end
				checked++;
			end
			if (in_valid && !in_stall)
				pending_results.insert(pending_results.size(),
					predict_key_store(action, iteration, seed_word));
			if (cfg_valid && cfg_ready)
				limit_reg = cfg_data;
			awaiting = pending_results.size();
		end
	end
endmodule
`default_nettype wire

/* sim/bounded_fifo_key_store_tb.sv */
`default_nettype none
module bounded_fifo_key_store_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam longint CYCLE_LIMIT = 60_000_000;
	localparam int RANDOM_PER_PHASE = 275;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [11:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [31:0] iteration;
	logic [63:0] seed_word;
	logic        out_valid;
	logic        out_stall;
	logic        found;
	logic [63:0] seed_out;
	logic [11:0] entry_count;
	logic [11:0] evicted_count;
	int          fail_count;
	int          awaiting;
	int          checked;
	longint      cycles;
	int          burst_left;
	int          stall_mode;
	int          stall_left;
	int          sent;
	int          settings_used;

	bounded_fifo_key_store u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .iteration(iteration), .seed_word(seed_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .seed_out(seed_out),
		.entry_count(entry_count), .evicted_count(evicted_count)
	);

	bounded_fifo_key_store_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .iteration(iteration), .seed_word(seed_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .seed_out(seed_out),
		.entry_count(entry_count), .evicted_count(evicted_count),
		.fail_count(fail_count), .awaiting(awaiting), .checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// receiver: stretches of no stall, light stall and heavy stall
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(5, 60);
			out_stall <= 1'b0;
		end else begin
			stall_left <= stall_left - 1;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic send_request(input logic [1:0] act, input logic [31:0] key,
		input logic [63:0] seed);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= act;
		iteration <= key;
		seed_word <= seed;
		sent++;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_limit(input logic [11:0] value);
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [1:0] pick_action();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return bfks_pkg::ACT_ADD;
		else if (r < 70)
			return bfks_pkg::ACT_QUERY;
		else if (r < 95)
			return bfks_pkg::ACT_REMOVE;
		return ACT_UNUSED;
	endfunction

	initial begin
		logic [11:0] limits[6];
		logic [31:0] key;
		int pool;
		limits = '{12'd8, 12'd64, 12'd4095, 12'd5, 12'd300, 12'd2048};
		cycles = 0;
		burst_left = 0;
		stall_left = 0;
		stall_mode = 0;
		sent = 0;
		settings_used = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = bfks_pkg::ACT_QUERY;
		iteration = '0;
		seed_word = '0;
		out_stall = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: misses, unused code, extremes, replace, hits
		send_request(bfks_pkg::ACT_QUERY, 32'd0, '1);
		send_request(bfks_pkg::ACT_REMOVE, 32'hffff_ffff, '1);
		send_request(ACT_UNUSED, 32'd0, 64'd5);
		send_request(bfks_pkg::ACT_ADD, 32'd0, 64'd0);
		send_request(bfks_pkg::ACT_ADD, 32'hffff_ffff, '1);
		send_request(bfks_pkg::ACT_ADD, 32'h5555_aaaa, 64'haaaa_5555_aaaa_5555);
		send_request(bfks_pkg::ACT_ADD, 32'd0, 64'h5555_aaaa_5555_aaaa);
		send_request(ACT_UNUSED, 32'd0, 64'd0);
		send_request(bfks_pkg::ACT_QUERY, 32'hffff_ffff, 64'd0);
		send_request(bfks_pkg::ACT_REMOVE, 32'hffff_ffff, 64'd0);
		send_request(bfks_pkg::ACT_REMOVE, 32'hffff_ffff, 64'd0);
		send_request(bfks_pkg::ACT_REMOVE, 32'd0, 64'd0);

		// zero limit behaves as one
		write_limit(12'd0);
		send_request(bfks_pkg::ACT_ADD, 32'd1, 64'd11);
		send_request(bfks_pkg::ACT_ADD, 32'd2, 64'd22);
		send_request(bfks_pkg::ACT_QUERY, 32'd1, 64'd0);
		write_limit(12'd1);
		send_request(bfks_pkg::ACT_ADD, 32'd3, 64'd33);

		// limit above capacity, fill to full, then add new and replace at full
		write_limit(12'd4095);
		for (int i = 0; i < 2049; i++)
			send_request(bfks_pkg::ACT_ADD, 32'h8000_0000 + i, {$urandom, $urandom});
		send_request(bfks_pkg::ACT_ADD, 32'h8000_0010, 64'd7);
		send_request(bfks_pkg::ACT_ADD, 32'h9000_0000, 64'd8);

		// lowered limit trims only on the next add
		write_limit(12'd3);
		send_request(bfks_pkg::ACT_QUERY, 32'h8000_0100, 64'd0);
		send_request(bfks_pkg::ACT_ADD, 32'h8000_0100, 64'd9);

		foreach (limits[p]) begin
			write_limit((p == 5) ? 12'($urandom_range(1, 2048)) : limits[p]);
			pool = (p == 2 || p == 5) ? 600 : 2 * limits[p] + 4;
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				key = ($urandom_range(0, 9) == 0) ? $urandom
					: 32'h0001_0000 + $urandom_range(0, pool - 1);
				send_request(pick_action(), key, {$urandom, $urandom});
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d requests, checked %0d results", sent, checked);
		$display("limit settings written: %0d", settings_used);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
